>>> hdl/sorted_priority_queue_top_defines.svh
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue_top; expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT_SAME(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NULL = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic [DATA_W-1:0] new_payload;
    logic signed [DATA_W-1:0] new_priority;
  } cell_ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds a payload and priority.
// Depends on spq_pkg; instantiated by sorted_priority_queue_top.
module spq_cell (
  input  logic clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic occ,
  input  logic left_ge,
  input  logic [spq_pkg::DATA_W-1:0] left_payload,
  input  logic signed [spq_pkg::DATA_W-1:0] left_priority,
  input  logic [spq_pkg::DATA_W-1:0] right_payload,
  input  logic signed [spq_pkg::DATA_W-1:0] right_priority,
  output logic ge,
  output logic [spq_pkg::DATA_W-1:0] cell_payload,
  output logic signed [spq_pkg::DATA_W-1:0] cell_priority
);

  logic [spq_pkg::DATA_W-1:0] payload_next;
  logic signed [spq_pkg::DATA_W-1:0] priority_next;

  assign ge = occ && (cell_priority >= ctrl.new_priority);

  always_comb begin
    payload_next = cell_payload;
    priority_next = cell_priority;
    unique case (ctrl.cmd)
      spq_pkg::CELL_INSERT: begin
        if (!ge && left_ge) begin
          payload_next = ctrl.new_payload;
          priority_next = ctrl.new_priority;
        end else if (!ge) begin
          payload_next = left_payload;
          priority_next = left_priority;
        end
      end
      spq_pkg::CELL_SHIFT: begin
        payload_next = right_payload;
        priority_next = right_priority;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_payload <= payload_next;
    cell_priority <= priority_next;
  end

endmodule

>>> hdl/sorted_priority_queue_top.sv
// Stable sorted priority queue: a chain of spq_cell slots kept in order, head in slot 0.
// Takes one request per cycle; every request gives one result in an output register.
// A request is accepted only in a cycle where no result waits or the waiting result is taken,
// so a stalled output stalls the input. The rate is set by the priority compare done
// combinationally in all cells at once. No clearing pass after reset.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_top_defines.svh.
`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] operation,
  input  logic [spq_pkg::DATA_W-1:0] payload,
  input  logic signed [spq_pkg::DATA_W-1:0] priority_req,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [spq_pkg::DATA_W-1:0] head_payload,
  output logic [spq_pkg::COUNT_W-1:0] entry_count
);

  localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

  logic [spq_pkg::COUNT_W-1:0] count;
  logic [spq_pkg::COUNT_W-1:0] count_next;
  logic [1:0] status_next;
  logic [spq_pkg::DATA_W-1:0] head_next;
  logic in_fire;
  spq_pkg::cell_ctrl_t ctrl;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] left_ge;
  logic [spq_pkg::DATA_W-1:0] cell_payload [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] cell_priority [DEPTH];
  logic [spq_pkg::DATA_W-1:0] left_payload [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] left_priority [DEPTH];
  logic [spq_pkg::DATA_W-1:0] right_payload [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] right_priority [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign in_fire = in_valid && in_ready;

  // decode request
  always_comb begin
    ctrl.cmd = spq_pkg::CELL_HOLD;
    ctrl.new_payload = payload;
    ctrl.new_priority = priority_req;
    count_next = count;
    status_next = spq_pkg::ST_OK;
    head_next = '0;
    unique case (operation)
      spq_pkg::OP_ENQUEUE: begin
        if (payload == '0) begin
          status_next = spq_pkg::ST_NULL;
        end else if (count == spq_pkg::COUNT_W'(DEPTH)) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          ctrl.cmd = spq_pkg::CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
        if (count == '0) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          head_next = cell_payload[0];
          if (operation == spq_pkg::OP_DEQUEUE) begin
            ctrl.cmd = spq_pkg::CELL_SHIFT;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      ctrl.cmd = spq_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = spq_pkg::COUNT_W'(i) < count;
    if (i == 0) begin : g_first
      assign left_ge[i] = 1'b1;
      assign left_payload[i] = '0;
      assign left_priority[i] = '0;
    end else begin : g_mid
      assign left_ge[i] = ge[i-1];
      assign left_payload[i] = cell_payload[i-1];
      assign left_priority[i] = cell_priority[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_payload[i] = cell_payload[i];
      assign right_priority[i] = cell_priority[i];
    end else begin : g_inner
      assign right_payload[i] = cell_payload[i+1];
      assign right_priority[i] = cell_priority[i+1];
    end

    spq_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occ            (occ[i]),
      .left_ge        (left_ge[i]),
      .left_payload   (left_payload[i]),
      .left_priority  (left_priority[i]),
      .right_payload  (right_payload[i]),
      .right_priority (right_priority[i]),
      .ge             (ge[i]),
      .cell_payload   (cell_payload[i]),
      .cell_priority  (cell_priority[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      status <= status_next;
      head_payload <= head_next;
      entry_count <= count_next;
    end
  end

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count <= spq_pkg::COUNT_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_insert_grows, in_fire && ctrl.cmd == spq_pkg::CELL_INSERT, count == $past(count) + 1'b1)
  `SPQ_ASSERT_SAME(a_empty_count, out_valid && status == spq_pkg::ST_EMPTY, entry_count == '0 && head_payload == '0)
  `SPQ_ASSERT_SAME(a_result_count, out_valid, entry_count == count)

endmodule
